/* hdl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int W_RAW = 24;
  localparam int W_D   = 26;
  localparam int W_T   = 29;
  localparam int W_C3  = 36;
  localparam int W_C2  = 56;
  localparam int W_C1  = 84;
  localparam int W_C0  = 110;
  localparam int W_A2  = 66;
  localparam int W_A1  = 96;
  localparam int W_A0  = 126;
  localparam int PR_SHIFT = 79;
  localparam int W_TEMP  = 17;
  localparam int W_PRESS = 27;

  localparam logic [W_TEMP-1:0]  TEMP_MAX  = 17'h0FFFF;
  localparam logic [W_TEMP-1:0]  TEMP_MIN  = 17'h10000;
  localparam logic [W_PRESS-1:0] PRESS_MAX = 27'h7FFFFFF;

  typedef enum logic [7:0] {
    REG_CAL_TEMP    = 8'd0,
    REG_CAL_PRESS_A = 8'd1,
    REG_CAL_PRESS_B = 8'd2,
    REG_CAL_PRESS_C = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } cal_t;

endpackage

/* hdl/bsc_dly.sv */
// ----------------------------------------------------------------------------
// bsc_dly
// Fixed-length delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module bsc_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[N-1];

endmodule

/* hdl/bsc_hstep.sv */
// ----------------------------------------------------------------------------
// bsc_hstep
// One Horner step y = c + acc * t, two stages: 32-bit slice products, then sum.
// ----------------------------------------------------------------------------
module bsc_hstep #(
  parameter int WA = 36,
  parameter int WB = 29,
  parameter int WC = 56,
  parameter int WO = 66
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0] acc,
  input  logic signed [WB-1:0] t,
  input  logic signed [WC-1:0] c,
  output logic signed [WO-1:0] y
);

  localparam int NC = (WA + 31) / 32;
  localparam int PW = 33 + WB;
  localparam int WT = WA - 32 * (NC - 1);

  logic signed [PW-1:0] pp_nxt [NC];
  logic signed [PW-1:0] pp_r   [NC];
  logic signed [WC-1:0] c_r;
  logic signed [WO-1:0] y_nxt;
  logic signed [WO-1:0] y_r;

  for (genvar i = 0; i < NC; i++) begin : g_pp
    logic signed [32:0] ch;
    if (i == NC - 1) begin : g_top
      assign ch = {{(33 - WT){acc[WA-1]}}, acc[WA-1:32*i]};
    end else begin : g_low
      assign ch = {1'b0, acc[32*i+31:32*i]};
    end
    assign pp_nxt[i] = ch * t;
  end

  always_comb begin
    y_nxt = WO'(c_r);
    for (int i = 0; i < NC; i++) begin
      y_nxt = y_nxt + (WO'(pp_r[i]) <<< (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      c_r  <= c;
      y_r  <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

/* hdl/bsc_tlin.sv */
// ----------------------------------------------------------------------------
// bsc_tlin
// Linear temperature, four stages: offset, products, t3 term, sum and floor.
// ----------------------------------------------------------------------------
module bsc_tlin
  import bsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  cal_t                  cal,
  input  logic [W_RAW-1:0]      raw_temp,
  output logic signed [W_T-1:0] tfix
);

  logic signed [W_D-1:0] d_nxt, d_r;
  logic signed [42:0]    dt2_nxt, dt2_r, dt2b_r;
  logic signed [51:0]    dd_nxt, dd_r;
  logic signed [59:0]    ddt3_nxt, ddt3_r;
  logic signed [61:0]    s;
  logic signed [W_T-1:0] tfix_r;

  always_comb begin
    d_nxt    = $signed({2'b0, raw_temp}) - $signed({2'b0, cal.t1, 8'b0});
    dt2_nxt  = d_r * $signed({1'b0, cal.t2});
    dd_nxt   = d_r * d_r;
    ddt3_nxt = dd_r * cal.t3;
    s        = (62'(dt2b_r) <<< 18) + 62'(ddt3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      dt2_r  <= dt2_nxt;
      dd_r   <= dd_nxt;
      dt2b_r <= dt2_r;
      ddt3_r <= ddt3_nxt;
      tfix_r <= s[60:32];
    end
  end

  assign tfix = tfix_r;

endmodule

/* hdl/bsc_pcoef.sv */
// ----------------------------------------------------------------------------
// bsc_pcoef
// Pressure-dependent Horner coefficients c0..c3 (c3..c1 at stage 4, c0 at 5).
// ----------------------------------------------------------------------------
module bsc_pcoef
  import bsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  cal_t                   cal,
  input  logic [W_RAW-1:0]       raw_press,
  output logic signed [W_C3-1:0] c3,
  output logic signed [W_C2-1:0] c2,
  output logic signed [W_C1-1:0] c1,
  output logic signed [W_C0-1:0] c0
);

  localparam logic signed [17:0] OFS = 18'sd16384;

  logic [W_RAW-1:0]      p_r, pa_r;
  logic [47:0]           p2_r;
  logic [71:0]           p3_r;
  logic signed [24:0]    pe;
  logic signed [17:0]    p1m, p2m;
  logic signed [42:0]    b1_r, b2_r;
  logic signed [32:0]    b3_r, b4_r;
  logic signed [64:0]    a9_r;
  logic signed [56:0]    a10_r;
  logic signed [80:0]    a11_r;
  logic signed [W_C3-1:0] c3_r;
  logic signed [W_C2-1:0] c2_r;
  logic signed [W_C1-1:0] c1_r;
  logic signed [W_C0-1:0] c0a_r, c0_r;

  always_comb begin
    pe  = $signed({1'b0, pa_r});
    p1m = 18'(cal.p1) - OFS;
    p2m = 18'(cal.p2) - OFS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= raw_press;
      p2_r  <= 48'(p_r) * 48'(p_r);
      pa_r  <= p_r;
      p3_r  <= 72'(48'(p2_r[23:0]) * 48'(pa_r))
             + (72'(48'(p2_r[47:24]) * 48'(pa_r)) << 24);
      b1_r  <= p1m * pe;
      b2_r  <= p2m * pe;
      b3_r  <= cal.p3 * pe;
      b4_r  <= cal.p4 * pe;
      a9_r  <= cal.p9 * $signed({1'b0, p2_r});
      a10_r <= cal.p10 * $signed({1'b0, p2_r});
      a11_r <= cal.p11 * $signed({1'b0, p3_r});
      c3_r  <= (W_C3'(cal.p8) <<< 22) + W_C3'(b4_r);
      c2_r  <= (W_C2'(cal.p7) <<< 45) + (W_C2'(b3_r) <<< 21);
      c1_r  <= (W_C1'($signed({1'b0, cal.p6})) <<< 63) + (W_C1'(b2_r) <<< 40)
             + (W_C1'(a10_r) <<< 21);
      c0a_r <= (W_C0'($signed({1'b0, cal.p5})) <<< 88) + (W_C0'(b1_r) <<< 65)
             + (W_C0'(a9_r) <<< 37);
      c0_r  <= c0a_r + (W_C0'(a11_r) <<< 20);
    end
  end

  assign c3 = c3_r;
  assign c2 = c2_r;
  assign c1 = c1_r;
  assign c0 = c0_r;

endmodule

/* hdl/baro_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Barometer temperature and pressure compensation, fully pipelined.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tdata: raw_press, raw_temp
//   out_     out  out_tvalid/out_tready tdata: temp_out, press_out; tuser: clipped
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle; the path runs through linear temperature, the three Horner
// steps in temperature and saturation into the output register.
// Reset clears calibration and valid bits. A stalled output holds the whole
// pipeline. No result is produced while t1 is zero.
// ----------------------------------------------------------------------------
module baro_sensor_compensation
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_press[23:0], raw_temp[47:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // temp_out[16:0], press_out[43:17], zero
  output logic        out_tuser,  // clipped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [39:0] cal_temp_r;
  logic [47:0] cal_press_a_r, cal_press_b_r;
  logic [31:0] cal_press_c_r;
  cal_t        cal;

  logic        en;
  logic [9:0]  vld_r;
  logic        out_valid_r;

  logic signed [W_T-1:0]  tfix4, t6, t8;
  logic signed [W_C3-1:0] c3_4;
  logic signed [W_C2-1:0] c2_4;
  logic signed [W_C1-1:0] c1_4, c1_6;
  logic signed [W_C0-1:0] c0_5, c0_8;
  logic signed [W_A2-1:0] acc2;
  logic signed [W_A1-1:0] acc1;
  logic signed [W_A0-1:0] acc0;

  logic [W_TEMP-1:0]  temp5_nxt, temp5_r, temp10;
  logic               tclip5_nxt, tclip5_r, tclip10;
  logic [W_PRESS-1:0] press_nxt, out_press_r;
  logic               pclip_nxt;
  logic [W_TEMP-1:0]  out_temp_r;
  logic               out_clip_r;

  assign cal = '{
    t1:  cal_temp_r[15:0],     t2:  cal_temp_r[31:16],    t3:  cal_temp_r[39:32],
    p1:  cal_press_a_r[15:0],  p2:  cal_press_a_r[31:16],
    p3:  cal_press_a_r[39:32], p4:  cal_press_a_r[47:40],
    p5:  cal_press_b_r[15:0],  p6:  cal_press_b_r[31:16],
    p7:  cal_press_b_r[39:32], p8:  cal_press_b_r[47:40],
    p9:  cal_press_c_r[15:0],  p10: cal_press_c_r[23:16],
    p11: cal_press_c_r[31:24]
  };

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r    <= '0;
      cal_press_a_r <= '0;
      cal_press_b_r <= '0;
      cal_press_c_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAL_TEMP:    cal_temp_r    <= cfg_data[39:0];
        REG_CAL_PRESS_A: cal_press_a_r <= cfg_data;
        REG_CAL_PRESS_B: cal_press_b_r <= cfg_data;
        REG_CAL_PRESS_C: cal_press_c_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en && rst_n;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[8:0], in_tvalid && (cal.t1 != 16'd0)};
      out_valid_r <= vld_r[9];
    end
  end

  bsc_tlin u_tlin (
    .clk      (clk),
    .en       (en),
    .cal      (cal),
    .raw_temp (in_tdata[47:24]),
    .tfix     (tfix4)
  );

  bsc_pcoef u_pcoef (
    .clk       (clk),
    .en        (en),
    .cal       (cal),
    .raw_press (in_tdata[23:0]),
    .c3        (c3_4),
    .c2        (c2_4),
    .c1        (c1_4),
    .c0        (c0_5)
  );

  // temperature output, stage 5
  always_comb begin
    if ((tfix4[28:24] == 5'h00) || (tfix4[28:24] == 5'h1F)) begin
      temp5_nxt  = tfix4[24:8];
      tclip5_nxt = 1'b0;
    end else begin
      temp5_nxt  = tfix4[28] ? TEMP_MIN : TEMP_MAX;
      tclip5_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp5_r  <= temp5_nxt;
      tclip5_r <= tclip5_nxt;
    end
  end

  bsc_dly #(.W(W_TEMP + 1), .N(5)) u_dly_temp (
    .clk (clk), .en (en), .d ({tclip5_r, temp5_r}), .q ({tclip10, temp10})
  );

  bsc_dly #(.W(W_T), .N(2)) u_dly_t6 (
    .clk (clk), .en (en), .d (tfix4), .q (t6)
  );

  bsc_dly #(.W(W_T), .N(2)) u_dly_t8 (
    .clk (clk), .en (en), .d (t6), .q (t8)
  );

  bsc_dly #(.W(W_C1), .N(2)) u_dly_c1 (
    .clk (clk), .en (en), .d (c1_4), .q (c1_6)
  );

  bsc_dly #(.W(W_C0), .N(3)) u_dly_c0 (
    .clk (clk), .en (en), .d (c0_5), .q (c0_8)
  );

  bsc_hstep #(.WA(W_C3), .WB(W_T), .WC(W_C2), .WO(W_A2)) u_h2 (
    .clk (clk), .en (en), .acc (c3_4), .t (tfix4), .c (c2_4), .y (acc2)
  );

  bsc_hstep #(.WA(W_A2), .WB(W_T), .WC(W_C1), .WO(W_A1)) u_h1 (
    .clk (clk), .en (en), .acc (acc2), .t (t6), .c (c1_6), .y (acc1)
  );

  bsc_hstep #(.WA(W_A1), .WB(W_T), .WC(W_C0), .WO(W_A0)) u_h0 (
    .clk (clk), .en (en), .acc (acc1), .t (t8), .c (c0_8), .y (acc0)
  );

  // pressure floor to 1/64 Pa and saturation
  always_comb begin
    if (acc0[W_A0-1]) begin
      press_nxt = '0;
      pclip_nxt = 1'b1;
    end else if (|acc0[W_A0-2:PR_SHIFT+W_PRESS]) begin
      press_nxt = PRESS_MAX;
      pclip_nxt = 1'b1;
    end else begin
      press_nxt = acc0[PR_SHIFT+W_PRESS-1:PR_SHIFT];
      pclip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp_r  <= temp10;
      out_press_r <= press_nxt;
      out_clip_r  <= tclip10 || pclip_nxt;
    end
  end

  assign out_tdata = {4'b0, out_press_r, out_temp_r};
  assign out_tuser = out_clip_r;

endmodule
